// File: rtl/gop_pkg.sv
// ---------------------------------------------------------------------------
// gop_pkg
// Types and constants shared by the Gram Hadamard product block.
// ---------------------------------------------------------------------------
package gop_pkg;

	localparam int MAX_RANK  = 8;
	localparam int IDX_W     = 3;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_RANK * MAX_RANK;
	localparam int ELEM_W    = 16;
	localparam int ACC_W     = 48;
	localparam int FRAC_BITS = 24;
	localparam int HALF_W    = 24;
	localparam int PROD_W    = 2 * ACC_W;

	localparam logic [ACC_W-1:0] ONE_Q   = ACC_W'(1) << FRAC_BITS;
	localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [2:0] REG_RANK = 3'd0;

	typedef struct packed {
		logic signed [15:0] element;
		logic               end_of_matrix;
		logic               end_of_set;
	} elem_t;

	typedef struct packed {
		logic signed [47:0] gram_value;
		logic [2:0]         row_index;
		logic [2:0]         col_index;
		logic               saturated;
		logic               last_of_run;
	} res_t;

	// one closed row, elements past the row end already zero
	typedef struct packed {
		logic [MAX_RANK-1:0][ELEM_W-1:0] vals;
		logic [3:0]                      rank;
		logic                            eom;
		logic                            eos;
	} job_t;

endpackage

// File: rtl/gop_front.sv
// ---------------------------------------------------------------------------
// gop_front
// Collects elements into rows and issues one job per closed row.
// ---------------------------------------------------------------------------
module gop_front import gop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] rank_cfg,
	input  logic       elem_valid,
	output logic       elem_stall,
	input  elem_t      elem_data,
	input  logic       q_full,
	output logic       push,
	output job_t       push_job
);

	logic [MAX_RANK-1:0][ELEM_W-1:0] row_q;
	logic [IDX_W-1:0]                col_q;
	logic [3:0]                      rank_eff;
	logic                            accept;
	logic                            eom;
	logic                            close;

	always_comb begin
		if (rank_cfg == 4'd0) begin
			rank_eff = 4'd1;
		end else if (rank_cfg > 4'(MAX_RANK)) begin
			rank_eff = 4'(MAX_RANK);
		end else begin
			rank_eff = rank_cfg;
		end
	end

	assign elem_stall = q_full;
	assign accept     = elem_valid && !q_full;
	assign eom        = elem_data.end_of_matrix || elem_data.end_of_set;
	assign close      = ({1'b0, col_q} + 4'd1 >= rank_eff) || eom;
	assign push       = accept && close;

	always_comb begin
		for (int k = 0; k < MAX_RANK; k++) begin
			if (k == int'(col_q)) begin
				push_job.vals[k] = elem_data.element;
			end else if (k < int'(col_q)) begin
				push_job.vals[k] = row_q[k];
			end else begin
				push_job.vals[k] = '0;
			end
		end
		push_job.rank = rank_eff;
		push_job.eom  = eom;
		push_job.eos  = elem_data.end_of_set;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q[col_q] <= elem_data.element;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			col_q <= close ? '0 : col_q + 3'd1;
		end
	end

endmodule

// File: rtl/gop_queue.sv
// ---------------------------------------------------------------------------
// gop_queue
// Two-entry job queue between row collection and the arithmetic engine.
// ---------------------------------------------------------------------------
module gop_queue import gop_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_job   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/gop_back.sv
// ---------------------------------------------------------------------------
// gop_back
// Row accumulation, Hadamard update and result emission over the stores.
// ---------------------------------------------------------------------------
module gop_back import gop_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  job_t q_job,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_ACC_RD = 9'b000000010,
		S_ACC_WR = 9'b000000100,
		S_HD_RD  = 9'b000001000,
		S_HD_MAG = 9'b000010000,
		S_HD_MUL = 9'b000100000,
		S_HD_WR  = 9'b001000000,
		S_EM_RD  = 9'b010000000,
		S_EM_LD  = 9'b100000000
	} state_t;

	state_t state_q;
	job_t   job_q;

	logic [IDX_W-1:0] i_q, j_q;
	logic [ADDR_W-1:0] addr;
	logic last_j, last_i;

	logic [ACC_W-1:0] acc_mem [DEPTH];
	logic [ACC_W-1:0] prod_mem [DEPTH];
	logic [DEPTH-1:0] acc_vld_q, prod_vld_q;
	logic [ACC_W-1:0] acc_rd_q, prod_rd_q;
	logic             acc_rv_q, prod_rv_q;
	logic [ACC_W-1:0] acc_cur, prod_cur;

	logic signed [31:0] mul_s1;
	logic [ACC_W-1:0]   ma_q, mb_q;
	logic               neg_q;
	logic [1:0]         cnt_q;
	logic [PROD_W-1:0]  pacc_q;
	logic [2*HALF_W-1:0] pp;
	logic [PROD_W-1:0]  pp_sh;

	logic [ACC_W+1:0]   sum50;
	logic [ACC_W-1:0]   acc_new;
	logic               acc_ovf;
	logic [PROD_W:0]    rsum;
	logic [PROD_W-FRAC_BITS:0] rr;
	logic               big;
	logic [ACC_W-1:0]   hd_val;
	logic               hd_sat;

	logic sat_q;
	logic res_accept;
	logic out_free;

	assign res_accept = res_valid && !res_stall;
	assign out_free   = !res_valid || res_accept;
	assign pop        = (state_q == S_IDLE) && q_valid;

	assign last_j = ({1'b0, j_q} + 4'd1 >= job_q.rank);
	assign last_i = ({1'b0, i_q} + 4'd1 >= job_q.rank);

	always_comb begin
		if (i_q <= j_q) begin
			addr = {i_q, j_q};
		end else begin
			addr = {j_q, i_q};
		end
	end

	assign acc_cur  = acc_rv_q ? acc_rd_q : '0;
	assign prod_cur = prod_rv_q ? prod_rd_q : ONE_Q;

	// accumulate with 48-bit clamp
	assign sum50   = {{2{acc_cur[ACC_W-1]}}, acc_cur} + {{18{mul_s1[31]}}, mul_s1};
	assign acc_ovf = (sum50[ACC_W+1] != sum50[ACC_W]) || (sum50[ACC_W] != sum50[ACC_W-1]);
	always_comb begin
		if (!acc_ovf) begin
			acc_new = sum50[ACC_W-1:0];
		end else if (sum50[ACC_W+1]) begin
			acc_new = SAT_MIN;
		end else begin
			acc_new = SAT_MAX;
		end
	end

	// partial products of the 48x48 magnitude multiply
	always_comb begin
		pp = (cnt_q[1] ? ma_q[ACC_W-1:HALF_W] : ma_q[HALF_W-1:0]) *
			(cnt_q[0] ? mb_q[ACC_W-1:HALF_W] : mb_q[HALF_W-1:0]);
		unique case (cnt_q)
			2'd0:    pp_sh = PROD_W'(pp);
			2'd3:    pp_sh = PROD_W'(pp) << (2 * HALF_W);
			default: pp_sh = PROD_W'(pp) << HALF_W;
		endcase
	end

	// round magnitude to nearest, ties away, then clamp
	assign rsum = {1'b0, pacc_q} + ((PROD_W + 1)'(1) << (FRAC_BITS - 1));
	assign rr   = rsum[PROD_W:FRAC_BITS];
	assign big  = |rr[PROD_W-FRAC_BITS:ACC_W];
	always_comb begin
		hd_sat = 1'b0;
		if (neg_q) begin
			if (big || (rr[ACC_W-1] && |rr[ACC_W-2:0])) begin
				hd_val = SAT_MIN;
				hd_sat = 1'b1;
			end else if (rr[ACC_W-1]) begin
				hd_val = SAT_MIN;
			end else begin
				hd_val = ~rr[ACC_W-1:0] + ACC_W'(1);
			end
		end else if (big || rr[ACC_W-1]) begin
			hd_val = SAT_MAX;
			hd_sat = 1'b1;
		end else begin
			hd_val = rr[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		acc_rd_q  <= acc_mem[addr];
		prod_rd_q <= prod_mem[addr];
		if (state_q == S_ACC_WR) begin
			acc_mem[addr] <= acc_new;
		end
		if (state_q == S_HD_WR) begin
			prod_mem[addr] <= hd_val;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (state_q == S_ACC_RD) begin
			mul_s1 <= $signed(job_q.vals[i_q]) * $signed(job_q.vals[j_q]);
		end
		if (state_q == S_HD_MAG) begin
			neg_q  <= prod_cur[ACC_W-1] ^ acc_cur[ACC_W-1];
			ma_q   <= prod_cur[ACC_W-1] ? ~prod_cur + ACC_W'(1) : prod_cur;
			mb_q   <= acc_cur[ACC_W-1] ? ~acc_cur + ACC_W'(1) : acc_cur;
			pacc_q <= '0;
		end
		if (state_q == S_HD_MUL) begin
			pacc_q <= pacc_q + pp_sh;
		end
		if (state_q == S_EM_LD && out_free) begin
			res_data.gram_value  <= prod_cur;
			res_data.row_index   <= i_q;
			res_data.col_index   <= j_q;
			res_data.saturated   <= sat_q;
			res_data.last_of_run <= last_i && last_j;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			cnt_q      <= '0;
			acc_vld_q  <= '0;
			prod_vld_q <= '0;
			acc_rv_q   <= 1'b0;
			prod_rv_q  <= 1'b0;
			sat_q      <= 1'b0;
			res_valid  <= 1'b0;
		end else begin
			acc_rv_q  <= acc_vld_q[addr];
			prod_rv_q <= prod_vld_q[addr];
			if (res_accept && state_q != S_EM_LD) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					if (q_valid) begin
						state_q <= S_ACC_RD;
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_WR;
				end
				S_ACC_WR: begin
					acc_vld_q[addr] <= 1'b1;
					if (acc_ovf) begin
						sat_q <= 1'b1;
					end
					state_q <= S_ACC_RD;
					if (!last_j) begin
						j_q <= j_q + 3'd1;
					end else if (!last_i) begin
						i_q <= i_q + 3'd1;
						j_q <= i_q + 3'd1;
					end else begin
						i_q <= '0;
						j_q <= '0;
						state_q <= job_q.eom ? S_HD_RD : S_IDLE;
					end
				end
				S_HD_RD: begin
					state_q <= S_HD_MAG;
				end
				S_HD_MAG: begin
					cnt_q   <= '0;
					state_q <= S_HD_MUL;
				end
				S_HD_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_HD_WR;
					end
				end
				S_HD_WR: begin
					prod_vld_q[addr] <= 1'b1;
					acc_vld_q[addr]  <= 1'b0;
					if (hd_sat) begin
						sat_q <= 1'b1;
					end
					state_q <= S_HD_RD;
					if (!last_j) begin
						j_q <= j_q + 3'd1;
					end else if (!last_i) begin
						i_q <= i_q + 3'd1;
						j_q <= i_q + 3'd1;
					end else begin
						i_q <= '0;
						j_q <= '0;
						state_q <= job_q.eos ? S_EM_RD : S_IDLE;
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_LD;
				end
				S_EM_LD: begin
					if (out_free) begin
						res_valid <= 1'b1;
						state_q   <= S_EM_RD;
						if (!last_j) begin
							j_q <= j_q + 3'd1;
						end else if (!last_i) begin
							i_q <= i_q + 3'd1;
							j_q <= '0;
						end else begin
							acc_vld_q  <= '0;
							prod_vld_q <= '0;
							sat_q      <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/gram_outer_product_hadamard.sv
// ---------------------------------------------------------------------------
// gram_outer_product_hadamard
// Streams factor rows into a saturating Gram accumulator, folds each matrix
// into a Hadamard product store and emits the symmetric result per set.
// ---------------------------------------------------------------------------
//  channel | signals                         | dir | payload
//  --------+---------------------------------+-----+---------------------
//  elem    | elem_valid / elem_stall         | in  | elem_t
//  res     | res_valid / res_stall           | out | res_t
//  config  | psel penable pwrite paddr ...   | in  | rank_in_use @ 0x0
//
//  Element accept: into the row buffer; a closed row waits in a two-entry
//  queue. Engine: each upper-triangle entry is read and written back per
//  row; at end of matrix each entry runs the 4-step 24x24 multiplier;
//  at end of set each entry is read and emitted. elem_stall rises when the
//  queue is full; res_stall holds the output register. Reset gives rank 8
//  and cleared stores via per-entry valid bits.
// ---------------------------------------------------------------------------
module gram_outer_product_hadamard import gop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        elem_valid,
	output logic        elem_stall,
	input  elem_t       elem_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res_data
);

	logic [3:0] rank_q;
	logic       q_full, push, pop, q_valid;
	job_t       push_job, q_job;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_RANK) ? {28'd0, rank_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= 4'd8;
		end else if (psel && penable && pwrite && paddr == REG_RANK) begin
			rank_q <= pwdata[3:0];
		end
	end

	gop_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rank_cfg   (rank_q),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.elem_data  (elem_data),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	gop_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	gop_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
